// ----- rtl/rv32i_dec_pkg.sv -----
// Package for the RV32I instruction decoder: opcodes, flag positions,
// the decode result type and the helpers shared by the decoder modules.
// Depends on nothing.
package rv32i_dec_pkg;

  localparam int unsigned InstrWidth = 32;

  typedef enum logic [6:0] {
    OPC_LOAD   = 7'b0000011,
    OPC_OP_IMM = 7'b0010011,
    OPC_AUIPC  = 7'b0010111,
    OPC_STORE  = 7'b0100011,
    OPC_OP     = 7'b0110011,
    OPC_LUI    = 7'b0110111,
    OPC_BRANCH = 7'b1100011,
    OPC_JALR   = 7'b1100111,
    OPC_JAL    = 7'b1101111,
    OPC_SYSTEM = 7'b1110011
  } opcode_e;

  localparam logic [3:0] AluPassImm = 4'b1111;
  localparam logic [4:0] LinkReg    = 5'b00001;

  localparam logic [1:0] OpaRs1 = 2'd0;
  localparam logic [1:0] OpaPc  = 2'd1;

  // Bit positions within the control flag word
  localparam int unsigned FlagBranch   = 0;
  localparam int unsigned FlagJump     = 1;
  localparam int unsigned FlagMemWrite = 2;
  localparam int unsigned FlagOpbImm   = 3;
  localparam int unsigned FlagLink     = 4;
  localparam int unsigned FlagWbSel    = 5;
  localparam int unsigned FlagMemRead  = 6;
  localparam int unsigned FlagCsr      = 7;
  localparam int unsigned FlagIllegal  = 8;
  localparam int unsigned NumFlags     = 9;

  typedef struct packed {
    logic                  reg_write;
    logic [1:0]            operand_a_select;
    logic [3:0]            alu_function;
    logic [1:0]            mem_size_select;
    logic [2:0]            branch_func;
    logic [11:0]           csr_address;
    logic [4:0]            rs1_index;
    logic [4:0]            rs2_index;
    logic [4:0]            rd_index;
    logic [31:0]           immediate;
    logic [NumFlags-1:0]   control_flags;
    logic                  toggle;
  } dec_result_t;

  // Byte, half and word access codes; other widths keep the previous code
  function automatic logic [1:0] size_code(input logic [2:0] funct3,
                                           input logic [1:0] prev);
    logic [1:0] code;
    case (funct3)
      3'd0:    code = 2'd1;
      3'd1:    code = 2'd2;
      3'd2:    code = 2'd3;
      default: code = prev;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/rv32i_dec_in_stage.sv -----
// Input register of the RV32I decoder: holds one instruction request.
// Depends on rv32i_dec_pkg.
module rv32i_dec_in_stage (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [rv32i_dec_pkg::InstrWidth-1:0]   instruction_i,
  input  logic                                   advance_i,
  output logic                                   valid_o,
  output logic [rv32i_dec_pkg::InstrWidth-1:0]   instruction_o
);
  import rv32i_dec_pkg::*;

  logic                  valid_q, valid_d;
  logic [InstrWidth-1:0] instr_q;
  logic                  take;

  // Free when empty or when the held request moves on this cycle
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      instr_q <= instruction_i;
    end
  end

  assign valid_o       = valid_q;
  assign instruction_o = instr_q;

endmodule

// ----- rtl/rv32i_dec_logic.sv -----
// Combinational decode of one RV32I instruction against the held fields.
// Depends on rv32i_dec_pkg.
module rv32i_dec_logic (
  input  logic [rv32i_dec_pkg::InstrWidth-1:0] instruction_i,
  input  rv32i_dec_pkg::dec_result_t           prev_i,
  output rv32i_dec_pkg::dec_result_t           result_o
);
  import rv32i_dec_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;

  assign opc = instruction_i[6:0];
  assign f3  = instruction_i[14:12];
  assign rd  = instruction_i[11:7];

  assign imm_i = {{20{instruction_i[31]}}, instruction_i[31:20]};
  assign imm_s = {{20{instruction_i[31]}}, instruction_i[31:25], instruction_i[11:7]};
  assign imm_b = {{19{instruction_i[31]}}, instruction_i[31], instruction_i[7],
                  instruction_i[30:25], instruction_i[11:8], 1'b0};
  assign imm_u = {instruction_i[31:12], 12'b0};
  assign imm_j = {{11{instruction_i[31]}}, instruction_i[31], instruction_i[19:12],
                  instruction_i[20], instruction_i[30:21], 1'b0};

  always_comb begin
    result_o                          = prev_i;
    result_o.reg_write                = 1'b0;
    result_o.branch_func              = 3'd0;
    result_o.rs1_index                = instruction_i[19:15];
    result_o.rs2_index                = 5'd0;
    result_o.control_flags            = '0;
    result_o.control_flags[FlagWbSel] = prev_i.control_flags[FlagWbSel];
    result_o.toggle                   = ~prev_i.toggle;

    case (opc)
      OPC_OP: begin
        result_o.reg_write                = 1'b1;
        result_o.rd_index                 = rd;
        result_o.alu_function             = {instruction_i[30], f3};
        result_o.operand_a_select         = OpaRs1;
        result_o.control_flags[FlagWbSel] = 1'b1;
        result_o.rs2_index                = instruction_i[24:20];
      end
      OPC_OP_IMM: begin
        result_o.reg_write                 = 1'b1;
        result_o.rd_index                  = rd;
        result_o.alu_function              = {1'b0, f3};
        result_o.operand_a_select          = OpaRs1;
        result_o.control_flags[FlagWbSel]  = 1'b1;
        result_o.immediate                 = imm_i;
        result_o.control_flags[FlagOpbImm] = 1'b1;
      end
      OPC_STORE: begin
        result_o.alu_function                = 4'd0;
        result_o.operand_a_select            = OpaRs1;
        result_o.mem_size_select             = size_code(f3, prev_i.mem_size_select);
        result_o.immediate                   = imm_s;
        result_o.rs2_index                   = instruction_i[24:20];
        result_o.control_flags[FlagMemWrite] = 1'b1;
        result_o.control_flags[FlagOpbImm]   = 1'b1;
      end
      OPC_LOAD: begin
        result_o.reg_write                  = 1'b1;
        result_o.rd_index                   = rd;
        result_o.alu_function               = 4'd0;
        result_o.operand_a_select           = OpaRs1;
        result_o.control_flags[FlagWbSel]   = 1'b0;
        result_o.mem_size_select            = size_code(f3, prev_i.mem_size_select);
        result_o.immediate                  = imm_i;
        result_o.control_flags[FlagMemRead] = 1'b1;
        result_o.control_flags[FlagOpbImm]  = 1'b1;
      end
      OPC_LUI: begin
        result_o.reg_write                 = 1'b1;
        result_o.rd_index                  = rd;
        result_o.alu_function              = AluPassImm;
        result_o.operand_a_select          = OpaPc;
        result_o.control_flags[FlagWbSel]  = 1'b1;
        result_o.immediate                 = imm_u;
        result_o.control_flags[FlagOpbImm] = 1'b1;
      end
      OPC_AUIPC: begin
        result_o.reg_write                 = 1'b1;
        result_o.rd_index                  = rd;
        result_o.alu_function              = 4'd0;
        result_o.operand_a_select          = OpaPc;
        result_o.immediate                 = imm_u;
        result_o.control_flags[FlagOpbImm] = 1'b1;
      end
      OPC_BRANCH: begin
        result_o.alu_function              = 4'd0;
        result_o.operand_a_select          = OpaPc;
        result_o.immediate                 = imm_b;
        result_o.rs2_index                 = instruction_i[24:20];
        result_o.branch_func               = f3;
        result_o.control_flags[FlagBranch] = 1'b1;
        result_o.control_flags[FlagOpbImm] = 1'b1;
      end
      OPC_JAL: begin
        result_o.reg_write                 = 1'b1;
        result_o.rd_index                  = (rd == 5'd0) ? LinkReg : rd;
        result_o.alu_function              = 4'd0;
        result_o.operand_a_select          = OpaPc;
        result_o.control_flags[FlagWbSel]  = 1'b1;
        result_o.immediate                 = imm_j;
        result_o.control_flags[FlagJump]   = 1'b1;
        result_o.control_flags[FlagLink]   = 1'b1;
        result_o.control_flags[FlagOpbImm] = 1'b1;
      end
      OPC_JALR: begin
        result_o.reg_write                 = 1'b1;
        result_o.rd_index                  = rd;
        result_o.alu_function              = 4'd0;
        result_o.operand_a_select          = OpaRs1;
        result_o.control_flags[FlagWbSel]  = 1'b1;
        result_o.immediate                 = imm_i;
        result_o.control_flags[FlagJump]   = 1'b1;
        result_o.control_flags[FlagLink]   = 1'b1;
        result_o.control_flags[FlagOpbImm] = 1'b1;
      end
      OPC_SYSTEM: begin
        result_o.reg_write              = (rd != 5'd0);
        result_o.rd_index               = rd;
        result_o.csr_address            = instruction_i[31:20];
        result_o.branch_func            = f3;
        result_o.control_flags[FlagCsr] = 1'b1;
      end
      default: begin
        result_o.control_flags[FlagIllegal] = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/rv32i_instruction_decoder_core.sv -----
// RV32I instruction decoder core: input register, decode logic, result register.
// A taken request is held in the input register; its decode is loaded into the result register when it advances.
// Throughput: one instruction per cycle; the input stalls only while both registers
// are full and the result is held off. The result register also keeps the held fields.
// Reset: asynchronous, active low; empties both stages and clears held fields
// and the toggle to zero.
module rv32i_instruction_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instruction_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               reg_write_o,
  output logic [1:0]         operand_a_select_o,
  output logic [3:0]         alu_function_o,
  output logic [1:0]         mem_size_select_o,
  output logic [2:0]         branch_func_o,
  output logic [11:0]        csr_address_o,
  output logic [4:0]         rs1_index_o,
  output logic [4:0]         rs2_index_o,
  output logic [4:0]         rd_index_o,
  output logic signed [31:0] immediate_o,
  output logic [8:0]         control_flags_o,
  output logic               toggle_o
);
  import rv32i_dec_pkg::*;

  logic                  stage_valid;
  logic [InstrWidth-1:0] stage_instr;
  logic                  advance;
  logic                  out_valid_q, out_valid_d;
  dec_result_t           res_q, res_d;

  // Move the held request into the result register whenever the result slot
  // is empty or its current result is being taken this cycle.
  assign advance = stage_valid && (!out_valid_q || !out_stall_i);

  rv32i_dec_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .instruction_i (instruction_i),
    .advance_i     (advance),
    .valid_o       (stage_valid),
    .instruction_o (stage_instr)
  );

  // Decode against the result register, which carries the held fields
  rv32i_dec_logic u_logic (
    .instruction_i (stage_instr),
    .prev_i        (res_q),
    .result_o      (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Result register: reset clears it because it also holds decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        res_q <= res_d;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign reg_write_o        = res_q.reg_write;
  assign operand_a_select_o = res_q.operand_a_select;
  assign alu_function_o     = res_q.alu_function;
  assign mem_size_select_o  = res_q.mem_size_select;
  assign branch_func_o      = res_q.branch_func;
  assign csr_address_o      = res_q.csr_address;
  assign rs1_index_o        = res_q.rs1_index;
  assign rs2_index_o        = res_q.rs2_index;
  assign rd_index_o         = res_q.rd_index;
  assign immediate_o        = $signed(res_q.immediate);
  assign control_flags_o    = res_q.control_flags;
  assign toggle_o           = res_q.toggle;

endmodule
